// File: hdl/assert_macros.svh
// assertion macros used by sorted_key_table_lookup_top
// each macro samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every edge
`define SKT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/skt_pkg.sv
// shared types and constants for the sorted key table
// no dependencies
package skt_pkg;

	// default sizes
	localparam int DEPTH_DEF       = 512;
	localparam int KEY_BITS_DEF    = 32;
	localparam int HANDLE_BITS_DEF = 16;

	// operation codes of the mode field
	typedef enum logic [1:0] {
		MODE_CLEAR  = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_LOOKUP = 2'd2
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_INS_CMP = 6'b000010,
		S_INS_PUT = 6'b000100,
		S_LK_CHK  = 6'b001000,
		S_LK_CMP  = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

endpackage

// File: hdl/skt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/sorted_key_table_lookup_top.sv
// Sorted key table: holds up to DEPTH (key, label handle) pairs in ascending key order in one
// ram, and serves clear, insert and lookup words one at a time through a small sequencer that
// shares a single key comparator. A lookup runs binary search probes, at most 10 at a full
// 512 entry table: each probe is one ram read plus one compare, and the search ends on the
// first matching probe, or with a miss once the search window is empty. An insert reads the
// last entry, moves larger entries up one slot, one per cycle through the ram's read and
// write ports, then writes the new pair into the freed slot, directly into an empty table;
// a refused insert, a clear or an unused mode goes straight to the result. in_ready is high
// whenever the sequencer is idle, also while a result still waits in the output register; a
// held result only delays the completion of the next word. The ram needs no clearing pass
// since only slots below the count are ever compared.
// depends on skt_pkg, skt_ram and assert_macros.svh
`include "assert_macros.svh"

module sorted_key_table_lookup_top
	import skt_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF,
	localparam int AW    = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [HANDLE_BITS-1:0] label_handle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [HANDLE_BITS-1:0] found_handle,
	output logic [CNT_W-1:0]       entry_count
);

	localparam int EW = KEY_BITS + HANDLE_BITS;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       j_q;
	logic [CNT_W-1:0]       lo_q;
	logic [CNT_W-1:0]       hi_q;
	logic [AW-1:0]          mid_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	status_t                res_status_q;
	logic [HANDLE_BITS-1:0] res_handle_q;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [HANDLE_BITS-1:0] found_handle_q;
	logic [CNT_W-1:0]       entry_count_q;

	logic                   in_fire;
	logic                   out_load;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [EW-1:0]          ram_rdata;
	logic [KEY_BITS-1:0]    rd_key;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic                   key_gt;
	logic                   key_eq;
	logic [CNT_W:0]         lo_hi_sum;
	logic [CNT_W-1:0]       cnt_m1;
	logic [CNT_W-1:0]       j_m1;
	logic [CNT_W-1:0]       j_m2;
	logic                   tbl_full;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign out_load = (state_q == S_DONE) & (~out_valid_q | out_ready);

	// shared key comparator on the word just read from the table
	assign rd_key    = ram_rdata[EW-1:HANDLE_BITS];
	assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
	assign key_gt    = rd_key > key_q;
	assign key_eq    = rd_key == key_q;

	// index arithmetic
	assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign cnt_m1    = count_q - CNT_W'(1);
	assign j_m1      = j_q - CNT_W'(1);
	assign j_m2      = j_q - CNT_W'(2);
	assign tbl_full  = (count_q == CNT_W'(DEPTH));

	// table ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q[AW-1:0];
		ram_wdata = {key_q, handle_q};
		ram_re    = 1'b0;
		ram_raddr = mid_q;
		case (state_q)
			S_IDLE: begin
				ram_re    = in_fire & (mode == MODE_INSERT);
				ram_raddr = cnt_m1[AW-1:0];
			end
			S_INS_CMP: begin
				ram_we    = key_gt;
				ram_wdata = ram_rdata;
				ram_re    = key_gt;
				ram_raddr = j_m2[AW-1:0];
			end
			S_INS_PUT: begin
				ram_we = 1'b1;
			end
			S_LK_CHK: begin
				ram_re    = 1'b1;
				ram_raddr = lo_hi_sum[AW:1];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	skt_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (mode)
							MODE_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							MODE_INSERT: begin
								if (tbl_full) begin
									state_q <= S_DONE;
								end else if (count_q == '0) begin
									state_q <= S_INS_PUT;
								end else begin
									state_q <= S_INS_CMP;
								end
							end
							MODE_LOOKUP: begin
								state_q <= S_LK_CHK;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS_CMP: begin
					if (!key_gt || j_m1 == '0) begin
						state_q <= S_INS_PUT;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_LK_CHK: begin
					if (lo_q < hi_q) begin
						state_q <= S_LK_CMP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LK_CMP: begin
					if (key_eq) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LK_CHK;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers of the current word
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					key_q        <= key;
					handle_q     <= label_handle;
					j_q          <= count_q;
					lo_q         <= '0;
					hi_q         <= count_q;
					res_handle_q <= '0;
					res_status_q <= ST_OK;
					if (mode == MODE_INSERT && tbl_full) begin
						res_status_q <= ST_FULL;
					end
				end
			end
			S_INS_CMP: begin
				if (key_gt) begin
					j_q <= j_m1;
				end
			end
			S_LK_CHK: begin
				mid_q <= lo_hi_sum[AW:1];
				if (!(lo_q < hi_q)) begin
					res_status_q <= ST_MISS;
				end
			end
			S_LK_CMP: begin
				if (key_eq) begin
					res_handle_q <= rd_handle;
				end else if (key_gt) begin
					hi_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q       <= res_status_q;
			found_handle_q <= res_handle_q;
			entry_count_q  <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_handle = found_handle_q;
	assign entry_count  = entry_count_q;

	// checks
	`SKT_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above table depth")
	`SKT_ASSERT_IMP(a_probe_range, state_q == S_LK_CMP, lo_q < hi_q && mid_q < hi_q, "probe outside search window")
	`SKT_ASSERT_NXT(a_insert_count, state_q == S_INS_PUT, count_q == $past(count_q) + CNT_W'(1), "insert did not bump count")
	`SKT_ASSERT_NXT(a_load_from_done, out_load, out_valid_q && entry_count_q == $past(count_q), "output word not loaded")

endmodule

// File: bench/tb_top.sv
// self-checking bench for sorted_key_table_lookup_top: directed, table-fill and random words
// with a table predictor in a scoreboard class, random gaps and stalls on both handshakes
// depends on skt_pkg and sorted_key_table_lookup_top
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam int TB_DEPTH     = DEPTH_DEF;
	localparam int KEY_W        = KEY_BITS_DEF;
	localparam int HND_W        = HANDLE_BITS_DEF;
	localparam int CNT_W        = $clog2(DEPTH_DEF + 1);
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 440;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 64;

	typedef struct packed {
		status_t            st;
		logic [HND_W-1:0]   handle;
		logic [CNT_W-1:0]   count;
	} table_answer_t;

	// table predictor and queue of answers still owed by the block
	class key_table_predictor;
		logic [KEY_W-1:0] keys [TB_DEPTH];
		logic [HND_W-1:0] handles [TB_DEPTH];
		int fill;
		table_answer_t pending_answers[$];
		int errors, checked;
		int n_clear, n_insert, n_full, n_hit, n_miss, n_unused, max_fill;

		function new();
			fill = 0;
			errors = 0;
			checked = 0;
			n_clear = 0; n_insert = 0; n_full = 0;
			n_hit = 0; n_miss = 0; n_unused = 0; max_fill = 0;
		endfunction

		// apply one accepted word and queue the answer it must produce
		function void note_word(logic [1:0] m, logic [KEY_W-1:0] k, logic [HND_W-1:0] h);
			table_answer_t ans;
			int j, lo, hi, mid;
			bit hit;
			ans.st = ST_OK;
			ans.handle = '0;
			case (m)
				MODE_CLEAR: begin
					fill = 0;
					n_clear++;
				end
				MODE_INSERT: begin
					n_insert++;
					if (fill >= TB_DEPTH) begin
						ans.st = ST_FULL;
						n_full++;
					end else begin
						// larger keys move up, equal keys stay below the new one
						j = fill;
						while (j > 0 && keys[j-1] > k) begin
							keys[j] = keys[j-1];
							handles[j] = handles[j-1];
							j--;
						end
						keys[j] = k;
						handles[j] = h;
						fill++;
						if (fill > max_fill)
							max_fill = fill;
					end
				end
				MODE_LOOKUP: begin
					// binary search, first probe that matches wins
					lo = 0;
					hi = fill;
					hit = 1'b0;
					while (lo < hi && !hit) begin
						mid = (lo + hi) / 2;
						if (keys[mid] == k) begin
							hit = 1'b1;
							ans.handle = handles[mid];
						end else if (keys[mid] < k)
							lo = mid + 1;
						else
							hi = mid;
					end
					if (hit)
						n_hit++;
					else begin
						ans.st = ST_MISS;
						n_miss++;
					end
				end
				default: n_unused++;
			endcase
			ans.count = fill[CNT_W-1:0];
			pending_answers.push_back(ans);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// compare one accepted result word with the oldest owed answer
		task check_answer(logic [1:0] st, logic [HND_W-1:0] fh, logic [CNT_W-1:0] cnt);
			table_answer_t exp;
			if (pending_answers.size() == 0) begin
				report($sformatf("result word with nothing owed: status %0d handle %h count %0d",
					st, fh, cnt));
				return;
			end
			exp = pending_answers.pop_front();
			checked++;
			if (st !== exp.st)
				report($sformatf("answer %0d status %0d, want %0d", checked, st, exp.st));
			if (fh !== exp.handle)
				report($sformatf("answer %0d handle %h, want %h", checked, fh, exp.handle));
			if (cnt !== exp.count)
				report($sformatf("answer %0d count %0d, want %0d", checked, cnt, exp.count));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       mode;
	logic [KEY_W-1:0] key;
	logic [HND_W-1:0] label_handle;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [HND_W-1:0] found_handle;
	logic [CNT_W-1:0] entry_count;

	key_table_predictor sb = new();
	int words_sent = 0;
	int hold_seq = 0;
	bit no_idle = 1'b0;

	sorted_key_table_lookup_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.key          (key),
		.label_handle (label_handle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_handle (found_handle),
		.entry_count  (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// overall limit on the run
	initial begin
		#3000000;
		$display("timeout with %0d answers still owed", sb.pending_answers.size());
		$display("sorted_key_table_lookup_top test failed");
		$finish;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(int style);
		case (style)
			0: return $urandom;
			1: return $urandom_range(0, 15);
			default: begin
				if ($urandom_range(0, 1))
					return $urandom_range(0, 3);
				return {KEY_W{1'b1}} - $urandom_range(0, 3);
			end
		endcase
	endfunction

	// offer one word, hold it until accepted, then maybe leave a gap
	task automatic send_word(logic [1:0] m, logic [KEY_W-1:0] k, logic [HND_W-1:0] h);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		label_handle <= h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(m, k, h);
		words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed answer has come back
	task automatic wait_all_answers();
		in_valid <= 1'b0;
		while (sb.pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// result side: random stalls, long hold when requested
	initial begin : result_sink
		int stall_left;
		int seen_hold;
		int r;
		stall_left = 0;
		seen_hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_answer(status, found_handle, entry_count);
			if (hold_seq != seen_hold) begin
				seen_hold = hold_seq;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !no_idle) begin
				r = $urandom_range(0, 99);
				if (r >= 96)
					stall_left = $urandom_range(10, 40);
				else if (r >= 76)
					stall_left = $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else
				out_ready <= 1'b1;
		end
	end

	// stimulus
	initial begin : word_source
		logic [KEY_W-1:0] k;
		int i, r, n_ins, n_look, style, idx, random_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_CLEAR;
		key = '0;
		label_handle = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, duplicates, unused mode, clear
		send_word(MODE_LOOKUP, '0, '0);
		send_word(MODE_UNUSED, '1, '1);
		send_word(MODE_INSERT, '0, '0);
		send_word(MODE_INSERT, '1, '1);
		send_word(MODE_INSERT, 32'h8000_0000, 16'h1234);
		send_word(MODE_INSERT, 32'h8000_0000, 16'h5678);
		send_word(MODE_INSERT, 32'h8000_0000, 16'h9abc);
		send_word(MODE_INSERT, 32'h7fff_ffff, 16'h00ff);
		send_word(MODE_INSERT, 32'h0000_0001, 16'h8000);
		send_word(MODE_LOOKUP, '0, '1);
		send_word(MODE_LOOKUP, '1, '0);
		send_word(MODE_LOOKUP, 32'h8000_0000, '0);
		send_word(MODE_LOOKUP, 32'h7fff_ffff, '0);
		send_word(MODE_LOOKUP, 32'h0000_0001, '0);
		send_word(MODE_LOOKUP, 32'h0000_0002, '0);
		send_word(MODE_LOOKUP, 32'hffff_fffe, '0);
		send_word(MODE_UNUSED, 32'h5555_aaaa, 16'ha5a5);
		send_word(MODE_CLEAR, '1, '1);
		send_word(MODE_LOOKUP, 32'h8000_0000, '0);
		send_word(MODE_INSERT, 32'h0000_0005, 16'h0042);
		send_word(MODE_LOOKUP, 32'h0000_0005, '0);
		send_word(MODE_CLEAR, '0, '0);
		wait_all_answers();

		// fill to the last slot behind a long result-side hold, then refused inserts and lookups
		send_word(MODE_CLEAR, $urandom, HND_W'($urandom));
		hold_seq <= hold_seq + 1;
		k = $urandom_range(0, 1000);
		for (i = 0; i < TB_DEPTH; i++) begin
			if (i >= TB_DEPTH - 8)
				send_word(MODE_INSERT, $urandom, HND_W'($urandom));
			else
				send_word(MODE_INSERT, k, HND_W'($urandom));
			if ($urandom_range(0, 9) >= 2)
				k = k + $urandom_range(1, 8000000);
		end
		send_word(MODE_INSERT, '0, HND_W'($urandom));
		send_word(MODE_INSERT, '1, HND_W'($urandom));
		for (i = 0; i < 24; i++) begin
			if (i % 3 == 0)
				send_word(MODE_LOOKUP, $urandom, HND_W'($urandom));
			else
				send_word(MODE_LOOKUP, sb.keys[$urandom_range(0, TB_DEPTH - 1)],
					HND_W'($urandom));
		end
		send_word(MODE_UNUSED, $urandom, HND_W'($urandom));
		wait_all_answers();

		// random: clear, fill a little, look up hits and misses, with some noise
		random_start = words_sent;
		while (words_sent < random_start + RANDOM_WORDS) begin
			no_idle <= ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0 || sb.fill > 200)
				send_word(MODE_CLEAR, $urandom, HND_W'($urandom));
			n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
			style = $urandom_range(0, 2);
			repeat (n_ins)
				send_word(MODE_INSERT, pick_key(style), HND_W'($urandom));
			n_look = $urandom_range(1, 2 * n_ins + 4);
			repeat (n_look) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					send_word(2'($urandom_range(0, 3)), $urandom, HND_W'($urandom));
				else if (r < 65 && sb.fill > 0) begin
					idx = $urandom_range(0, sb.fill - 1);
					send_word(MODE_LOOKUP, sb.keys[idx], HND_W'($urandom));
				end else if (r < 80 && sb.fill > 0) begin
					idx = $urandom_range(0, sb.fill - 1);
					k = $urandom_range(0, 1) ? sb.keys[idx] + 1 : sb.keys[idx] - 1;
					send_word(MODE_LOOKUP, k, HND_W'($urandom));
				end else
					send_word(MODE_LOOKUP, pick_key(style), HND_W'($urandom));
			end
		end
		in_valid <= 1'b0;
		no_idle <= 1'b0;

		// drain and let any stray word show up
		wait_all_answers();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d words sent: %0d inserts (%0d refused on a full table), %0d lookups %s",
			words_sent, sb.n_insert, sb.n_full, sb.n_hit + sb.n_miss,
			$sformatf("(%0d hit, %0d missed)", sb.n_hit, sb.n_miss));
		$display("%0d clears, %0d unused-mode words, %0d answers compared, %s",
			sb.n_clear, sb.n_unused, sb.checked,
			$sformatf("deepest table %0d entries", sb.max_fill));
		if (sb.errors == 0)
			$display("sorted_key_table_lookup_top test passed");
		else
			$display("sorted_key_table_lookup_top test failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/sorted_key_table_lookup_top.sv
bench/tb_top.sv
